// ----- rtl/imoc_pkg.sv -----
package imoc_pkg;

   // input beat
   typedef struct packed {
      logic               kind;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_type;

   // result beat
   typedef struct packed {
      logic [2:0]  orientation;
      logic        moving;
      logic        shaking;
      logic        tap;
      logic [15:0] magnitude;
   } rsp_type;

   localparam int unsigned SMOOTH_W = 24;
   localparam int unsigned CSR_W    = 16;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 24'd1048576;
   localparam logic [SMOOTH_W-1:0] SMOOTH_MAX   = 24'hFFFFFF;

   // request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SHAKE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTION = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT   = 2'd3;

   localparam logic [15:0] SHAKE_RESET  = 16'd10240;
   localparam logic [15:0] TAP_RESET    = 16'd6144;
   localparam logic [15:0] MOTION_RESET = 16'd614;
   localparam logic [14:0] TILT_RESET   = 15'd3277;

   // orientation codes
   localparam logic [2:0] ORIENT_UP       = 3'd0;
   localparam logic [2:0] ORIENT_DOWN     = 3'd1;
   localparam logic [2:0] ORIENT_RIGHT    = 3'd2;
   localparam logic [2:0] ORIENT_LEFT     = 3'd3;
   localparam logic [2:0] ORIENT_UPRIGHT  = 3'd4;
   localparam logic [2:0] ORIENT_UPSIDE   = 3'd5;
   localparam logic [2:0] ORIENT_ANGLED   = 3'd6;

endpackage

// ----- rtl/imu_motion_orientation_classifier.sv -----
// Channel   Ports                          Direction  Beat
// -------   -----------------------------  ---------  -----------------------------------
// request   req_valid/req_ready/req_data   in         sample (x,y,z) or status query
// response  rsp_valid/rsp_ready/rsp_data   out        orientation, flags, magnitude
// csr       csr_we/csr_index/csr_wdata     in         threshold write, no wait, no readback
//
// A sample beat is worked by the calc engine: square/accumulate steps over x, y and z,
// a restoring square-root step for each root bit, then a reciprocal multiply and a
// correction for the divide by ten. A query beat skips the calc engine and goes straight
// to the commit state. req_ready is high only while idle.
// Synchronous active-high reset; thresholds and filter state return to defaults.
// The response register frees the sequencer; the next beat waits in the commit state
// while an earlier response is stalled by rsp_ready.
module imu_motion_orientation_classifier #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  imoc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output imoc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [imoc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [imoc_pkg::CSR_W-1:0]          csr_wdata
);

   // raw fields are 16 bits; the low SAMPLE_BITS of the zero-extended field are used
   localparam int RAW_W  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
   localparam int CMP_W  = RAW_W + 1;
   localparam int MAGX_W = RAW_W;
   localparam int MW     = (SAMPLE_BITS + 8 > imoc_pkg::SMOOTH_W) ? SAMPLE_BITS + 8
                                                                 : imoc_pkg::SMOOTH_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;

   // thresholds
   logic [15:0] shake_ff, tap_thr_ff, motion_ff;
   logic [14:0] tilt_ff;

   // classifier state
   logic [imoc_pkg::SMOOTH_W-1:0] smooth_ff, smooth_in;
   logic                          tap_ff, tap_in;
   logic [2:0]                    orient_ff, orient_in;
   logic                          moving_ff, moving_in;
   logic                          shaking_ff, shaking_in;
   logic [15:0]                   mag_ff, mag_in;

   imoc_pkg::req_type req_ff;
   imoc_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic req_fire;
   logic calc_start;
   logic calc_done;
   logic commit;

   logic [SAMPLE_BITS-1:0]        calc_mag;
   logic [imoc_pkg::SMOOTH_W-1:0] calc_smooth;

   logic [RAW_W-1:0]              raw_x, raw_y, raw_z;
   logic signed [SAMPLE_BITS-1:0] sx, sy, sz;
   logic signed [CMP_W-1:0]       ex, ey, ez, tilt_pos, tilt_neg;
   logic [2:0]                    orient_new;
   logic [MAGX_W-1:0]             magx;
   logic                          shake_new, tap_hit, moving_new;
   logic [15:0]                   mag_sat;
   logic [MW-1:0]                 mag_fx, old_w, diff;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign calc_start = req_fire && (req_data.kind == imoc_pkg::KIND_SAMPLE);
   assign commit     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // sample extraction
   assign raw_x = RAW_W'($unsigned(req_ff.accel_x));
   assign raw_y = RAW_W'($unsigned(req_ff.accel_y));
   assign raw_z = RAW_W'($unsigned(req_ff.accel_z));
   assign sx = $signed(raw_x[SAMPLE_BITS-1:0]);
   assign sy = $signed(raw_y[SAMPLE_BITS-1:0]);
   assign sz = $signed(raw_z[SAMPLE_BITS-1:0]);

   imoc_calc #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_calc (
      .clock      (clock),
      .reset      (reset),
      .start      (calc_start),
      .sample_x   (sx),
      .sample_y   (sy),
      .sample_z   (sz),
      .smooth_old (smooth_ff),
      .done       (calc_done),
      .mag        (calc_mag),
      .smooth_next(calc_smooth)
   );

   // orientation: z first, then x, then y; equal to the threshold is not beyond it
   assign ex = CMP_W'(sx);
   assign ey = CMP_W'(sy);
   assign ez = CMP_W'(sz);
   assign tilt_pos = $signed(CMP_W'(tilt_ff));
   assign tilt_neg = -tilt_pos;

   always_comb begin
      if (ez > tilt_pos)       orient_new = imoc_pkg::ORIENT_UP;
      else if (ez < tilt_neg)  orient_new = imoc_pkg::ORIENT_DOWN;
      else if (ex > tilt_pos)  orient_new = imoc_pkg::ORIENT_RIGHT;
      else if (ex < tilt_neg)  orient_new = imoc_pkg::ORIENT_LEFT;
      else if (ey > tilt_pos)  orient_new = imoc_pkg::ORIENT_UPRIGHT;
      else if (ey < tilt_neg)  orient_new = imoc_pkg::ORIENT_UPSIDE;
      else                     orient_new = imoc_pkg::ORIENT_ANGLED;
   end

   // magnitude tests use the full root; output saturates at 16 bits
   assign magx      = MAGX_W'(calc_mag);
   assign shake_new = magx > MAGX_W'(shake_ff);
   assign tap_hit   = (magx > MAGX_W'(tap_thr_ff)) && !shake_new;
   assign mag_sat   = (magx > MAGX_W'(16'hFFFF)) ? 16'hFFFF : magx[15:0];

   // deviation from the smoothed magnitude, both with 8 fraction bits
   assign mag_fx     = MW'(calc_mag) << 8;
   assign old_w      = MW'(smooth_ff);
   assign diff       = (mag_fx > old_w) ? (mag_fx - old_w) : (old_w - mag_fx);
   assign moving_new = diff > (MW'(motion_ff) << 8);

   always_comb begin
      state_in     = state_ff;
      smooth_in    = smooth_ff;
      tap_in       = tap_ff;
      orient_in    = orient_ff;
      moving_in    = moving_ff;
      shaking_in   = shaking_ff;
      mag_in       = mag_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_data.kind == imoc_pkg::KIND_SAMPLE) ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            if (calc_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (req_ff.kind == imoc_pkg::KIND_QUERY) begin
                  // report the held flag, then clear it
                  rsp_in = '{orientation: orient_ff, moving: moving_ff,
                             shaking: shaking_ff, tap: tap_ff, magnitude: mag_ff};
                  tap_in = 1'b0;
               end else begin
                  smooth_in  = calc_smooth;
                  tap_in     = tap_ff || tap_hit;
                  orient_in  = orient_new;
                  moving_in  = moving_new;
                  shaking_in = shake_new;
                  mag_in     = mag_sat;
                  rsp_in = '{orientation: orient_new, moving: moving_new,
                             shaking: shake_new, tap: tap_ff || tap_hit,
                             magnitude: mag_sat};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         smooth_ff    <= imoc_pkg::SMOOTH_RESET;
         tap_ff       <= 1'b0;
         orient_ff    <= imoc_pkg::ORIENT_UP;
         moving_ff    <= 1'b0;
         shaking_ff   <= 1'b0;
         mag_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         smooth_ff    <= smooth_in;
         tap_ff       <= tap_in;
         orient_ff    <= orient_in;
         moving_ff    <= moving_in;
         shaking_ff   <= shaking_in;
         mag_ff       <= mag_in;
      end
      if (req_fire) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shake_ff   <= imoc_pkg::SHAKE_RESET;
         tap_thr_ff <= imoc_pkg::TAP_RESET;
         motion_ff  <= imoc_pkg::MOTION_RESET;
         tilt_ff    <= imoc_pkg::TILT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            imoc_pkg::CSR_SHAKE:  shake_ff   <= csr_wdata;
            imoc_pkg::CSR_TAP:    tap_thr_ff <= csr_wdata;
            imoc_pkg::CSR_MOTION: motion_ff  <= csr_wdata;
            imoc_pkg::CSR_TILT:   tilt_ff    <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a beat is in flight");

   a_done_only_running: assert property (@(posedge clock) disable iff (reset)
      calc_done |-> state_ff == ST_RUN)
      else $error("calc engine finished outside a sample beat");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised without a commit");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_valid_ff && !rsp_ready |=> state_ff == ST_DONE)
      else $error("commit overran a stalled response");
`endif

endmodule

// ----- rtl/imoc_calc.sv -----
module imoc_calc #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [SAMPLE_BITS-1:0]       sample_x,
   input  logic signed [SAMPLE_BITS-1:0]       sample_y,
   input  logic signed [SAMPLE_BITS-1:0]       sample_z,
   input  logic [imoc_pkg::SMOOTH_W-1:0]       smooth_old,
   output logic                                done,
   output logic [SAMPLE_BITS-1:0]              mag,
   output logic [imoc_pkg::SMOOTH_W-1:0]       smooth_next
);

   localparam int SUM_W  = 2 * SAMPLE_BITS;
   localparam int NUM_W  = ((SAMPLE_BITS + 8 > 28) ? SAMPLE_BITS + 8 : 28) + 1;
   localparam int DIV_W  = NUM_W + (NUM_W % 2);
   localparam int PROD_W = 2 * DIV_W;
   localparam int CNT_W  = $clog2(SAMPLE_BITS);

   // floor(2^DIV_W / 10); the product estimate is low by at most one
   localparam logic [DIV_W-1:0] RECIP = DIV_W'((64'd1 << DIV_W) / 64'd10);
   localparam logic [DIV_W-1:0] TEN   = DIV_W'(10);

   localparam logic [2:0] C_IDLE = 3'd0;
   localparam logic [2:0] C_SQ   = 3'd1;
   localparam logic [2:0] C_ROOT = 3'd2;
   localparam logic [2:0] C_PREP = 3'd3;
   localparam logic [2:0] C_DIV  = 3'd4;
   localparam logic [2:0] C_FIN  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0] n_ff, n_in;
   logic [SUM_W-1:0] root_ff, root_in;
   logic [SUM_W-1:0] bit_ff, bit_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] quot_ff, quot_in;
   logic             done_ff, done_in;

   logic signed [SAMPLE_BITS-1:0] axis_sel;
   logic signed [SUM_W-1:0]       axis_sq;
   logic [SUM_W:0]                trial;
   logic [PROD_W-1:0]             recip_prod;
   logic [DIV_W-1:0]              quot_rem;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    axis_sel = sample_x;
         2'd1:    axis_sel = sample_y;
         2'd2:    axis_sel = sample_z;
         default: axis_sel = '0;
      endcase
   end

   assign axis_sq = axis_sel * axis_sel;

   // one step of the restoring square root
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   // divide by ten: reciprocal multiply, then one correction step
   assign recip_prod = PROD_W'(num_ff) * PROD_W'(RECIP);
   assign quot_rem   = num_ff - (quot_ff << 3) - (quot_ff << 1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      n_in     = n_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      num_in   = num_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               state_in = C_SQ;
               cnt_in   = '0;
            end
         end
         C_SQ: begin
            prod_in = axis_sq;
            n_in    = (cnt_ff == '0) ? '0 : n_ff + prod_ff;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(3)) begin
               state_in = C_ROOT;
               cnt_in   = '0;
               root_in  = '0;
               bit_in   = SUM_W'(1) << (SUM_W - 2);
            end
         end
         C_ROOT: begin
            if ({1'b0, n_ff} >= trial) begin
               n_in    = n_ff - trial[SUM_W-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SAMPLE_BITS - 1)) begin
               state_in = C_PREP;
               cnt_in   = '0;
            end
         end
         C_PREP: begin
            // 9*old + mag*256
            num_in = (DIV_W'(smooth_old) << 3) + DIV_W'(smooth_old)
                     + (DIV_W'(root_ff[SAMPLE_BITS-1:0]) << 8);
            state_in = C_DIV;
         end
         C_DIV: begin
            quot_in  = recip_prod[PROD_W-1 -: DIV_W];
            state_in = C_FIN;
         end
         C_FIN: begin
            num_in   = quot_ff + ((quot_rem >= TEN) ? DIV_W'(1) : DIV_W'(0));
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      n_ff    <= n_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign mag  = root_ff[SAMPLE_BITS-1:0];
   assign smooth_next = (num_ff > DIV_W'(imoc_pkg::SMOOTH_MAX)) ? imoc_pkg::SMOOTH_MAX
                                                               : num_ff[imoc_pkg::SMOOTH_W-1:0];

endmodule

// ----- sim/tb_imu_motion_orientation_classifier.sv -----
module tb_imu_motion_orientation_classifier;
   import imoc_pkg::*;

   // receiver hold-off: after this many result beats, refuse results for a
   // long stretch so the block backs up and req_ready stays low
   localparam int LONG_STALL_AT     = 400;
   localparam int LONG_STALL_CYCLES = 500;
   localparam int PHASE_BEATS       = 140;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   imu_motion_orientation_classifier uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // beats waiting to be offered, and status beats the block still owes us
   req_type imu_beats_to_send[$];
   rsp_type status_expected[$];

   int  issued_beats   = 0;   // raised by the driver
   int  accepted_beats = 0;   // req handshakes seen at posedge
   int  status_beats   = 0;   // rsp handshakes seen at posedge
   int  fail_count     = 0;
   bit  idle_on        = 1'b1;

   // predictor copy of the thresholds
   logic [15:0] shake_lim;
   logic [15:0] tap_lim;
   logic [15:0] motion_lim;
   logic [14:0] tilt_lim;

   // predictor copy of the filter and held classification
   logic [SMOOTH_W-1:0] smooth_q8    = SMOOTH_RESET;
   logic                tap_latched  = 1'b0;
   logic [2:0]          held_orient  = ORIENT_UP;
   logic                held_moving  = 1'b0;
   logic                held_shaking = 1'b0;
   logic [15:0]         held_mag     = 16'd0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop, well past the slowest legal run
   initial begin
      #6000000;
      $display("imu_motion_orientation_classifier test failed");
      $finish;
   end

   // gap length: mostly zero or short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 20);
      return $urandom_range(40, 80);
   endfunction

   function automatic req_type imu_beat(logic kind, int x, int y, int z);
      req_type b;
      b.kind    = kind;
      b.accel_x = x[15:0];
      b.accel_y = y[15:0];
      b.accel_z = z[15:0];
      return b;
   endfunction

   // One step of the classifier. Samples update the filter and the held
   // status; queries report the held status and hand back (and clear) the
   // tap latch.
   function automatic rsp_type step_motion_status(req_type beat);
      rsp_type             st;
      longint              sx, sy, sz, t;
      longint unsigned     energy, mag, cand, mag_q8, diff, nxt;
      if (beat.kind == KIND_QUERY) begin
         st.tap      = tap_latched;
         tap_latched = 1'b0;
      end else begin
         sx = longint'($signed(beat.accel_x));
         sy = longint'($signed(beat.accel_y));
         sz = longint'($signed(beat.accel_z));
         energy = sx * sx + sy * sy + sz * sz;
         // floor square root, one result bit at a time from the top
         mag = 0;
         for (int b = 16; b >= 0; b--) begin
            cand = mag | (64'd1 << b);
            if (cand * cand <= energy) mag = cand;
         end
         mag_q8 = mag << 8;
         diff   = (mag_q8 > smooth_q8) ? mag_q8 - smooth_q8 : smooth_q8 - mag_q8;
         held_shaking = (mag > shake_lim);
         held_moving  = (diff > {motion_lim, 8'd0});
         // filter: 0.9 old + 0.1 new, truncated, compared before update
         nxt = (longint'(smooth_q8) * 9 + mag_q8) / 10;
         smooth_q8 = (nxt > SMOOTH_MAX) ? SMOOTH_MAX : nxt[SMOOTH_W-1:0];
         if (mag > tap_lim && !held_shaking) tap_latched = 1'b1;
         // z first, then x, then y; equal to the limit is not beyond it
         t = longint'(tilt_lim);
         if (sz > t)       held_orient = ORIENT_UP;
         else if (sz < -t) held_orient = ORIENT_DOWN;
         else if (sx > t)  held_orient = ORIENT_RIGHT;
         else if (sx < -t) held_orient = ORIENT_LEFT;
         else if (sy > t)  held_orient = ORIENT_UPRIGHT;
         else if (sy < -t) held_orient = ORIENT_UPSIDE;
         else              held_orient = ORIENT_ANGLED;
         held_mag = (mag > 65535) ? 16'hFFFF : mag[15:0];
         st.tap   = tap_latched;
      end
      st.orientation = held_orient;
      st.moving      = held_moving;
      st.shaking     = held_shaking;
      st.magnitude   = held_mag;
      return st;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // only called while the block is idle
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SHAKE:  shake_lim  = value;
         CSR_TAP:    tap_lim    = value;
         CSR_MOTION: motion_lim = value;
         CSR_TILT:   tilt_lim   = value[14:0];
         default: begin
         end
      endcase
   endtask

   // sender drained, nothing in flight, nothing owed
   task automatic wait_idle();
      do @(posedge clock);
      while (imu_beats_to_send.size() != 0 || req_valid || status_expected.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Driver: holds a beat until the monitor has counted its handshake,
   // then waits out a random gap before the next one when idle_on is set.
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!(req_valid && accepted_beats != issued_beats)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (imu_beats_to_send.size() != 0) begin
            req_data  <= imu_beats_to_send.pop_front();
            req_valid <= 1'b1;
            issued_beats++;
            send_gap = idle_on ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here.
   int  stall_left      = 0;
   bit  long_stall_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!long_stall_done && status_beats >= LONG_STALL_AT) begin
         long_stall_done = 1'b1;
         stall_left      = LONG_STALL_CYCLES;
         rsp_ready      <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
         rsp_ready <= (stall_left == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predict on every accepted req beat, check every rsp beat
   // against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            status_expected.push_back(step_motion_status(req_data));
            accepted_beats++;
         end
         if (rsp_valid && rsp_ready) begin
            status_beats++;
            if (status_expected.size() == 0) begin
               $error("rsp beat with no expectation pending");
               fail_count++;
            end else begin
               want = status_expected.pop_front();
               check_field("orientation", want.orientation, rsp_data.orientation);
               check_field("moving", want.moving, rsp_data.moving);
               check_field("shaking", want.shaking, rsp_data.shaking);
               check_field("tap", want.tap, rsp_data.tap);
               check_field("magnitude", want.magnitude, rsp_data.magnitude);
            end
         end
      end
   end

   initial begin
      int phase, n, r, t, hi, axis, g, x, y, z;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = CSR_SHAKE;
      csr_wdata = '0;

      shake_lim    = SHAKE_RESET;
      tap_lim      = TAP_RESET;
      motion_lim   = MOTION_RESET;
      tilt_lim     = TILT_RESET;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed, reset thresholds (shake 10240, tap 6144, tilt 3277)
      imu_beats_to_send.push_back(imu_beat(KIND_QUERY, 0, 0, 0));       // held reset status
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, 0, 4096));   // at rest, face up
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, 0, 3277));   // on the tilt limit
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, 0, -3277));
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, 0, 3278));
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, 0, -3278));
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 3278, 0, 0));
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, -3278, 0, 0));
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, 3278, 0));
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, -3278, 0));
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 3277, -3277, 3277));
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 10240, 0, 0));  // tap, shake limit equal
      imu_beats_to_send.push_back(imu_beat(KIND_QUERY, 0, 0, 0));       // tap reported, cleared
      imu_beats_to_send.push_back(imu_beat(KIND_QUERY, 0, 0, 0));       // tap gone
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 10241, 0, 0));  // shaking masks tap
      imu_beats_to_send.push_back(imu_beat(KIND_QUERY, 0, 0, 0));
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 6144, 0, 0));   // tap limit equal
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 6145, 0, 0));
      imu_beats_to_send.push_back(imu_beat(KIND_QUERY, 0, 0, 0));
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 32767, 32767, 32767));
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, -32768, -32768, -32768)); // largest mag
      imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, 0, 0));
      imu_beats_to_send.push_back(imu_beat(KIND_QUERY, -1, -1, -1));    // accel ignored

      for (phase = 0; phase < 6; phase++) begin
         // sender pauses here until every status beat is back
         wait_idle();
         case (phase)
            0: begin
               write_csr(CSR_SHAKE, 16'h0000);
               write_csr(CSR_TAP, 16'h0000);
               write_csr(CSR_MOTION, 16'h0000);
               write_csr(CSR_TILT, 16'h0000);
            end
            1: begin
               write_csr(CSR_SHAKE, 16'hFFFF);
               write_csr(CSR_TAP, 16'hFFFF);
               write_csr(CSR_MOTION, 16'hFFFF);
               write_csr(CSR_TILT, 16'hFFFF);
            end
            3: begin
               write_csr(CSR_SHAKE, SHAKE_RESET);
               write_csr(CSR_TAP, TAP_RESET);
               write_csr(CSR_MOTION, MOTION_RESET);
               write_csr(CSR_TILT, {1'b0, TILT_RESET});
            end
            default: begin
               write_csr(CSR_SHAKE, 16'($urandom_range(4096, 20000)));
               write_csr(CSR_TAP, 16'($urandom_range(2000, 12000)));
               write_csr(CSR_MOTION, 16'($urandom_range(0, 3000)));
               write_csr(CSR_TILT, 16'($urandom_range(0, 8000)));
            end
         endcase
         idle_on = (phase != 4);   // one phase runs flat out

         // z right at and just past the tilt limit for this setting
         t  = int'(tilt_lim);
         hi = (t == 32767) ? 32767 : t + 1;
         imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, 0, t));
         imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, 0, hi));
         imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, 0, -t));
         imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, 0, 0, -t - 1));

         for (n = 0; n < PHASE_BEATS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               imu_beats_to_send.push_back(
                  imu_beat(KIND_QUERY, $urandom(), $urandom(), $urandom()));
            end else if (r < 35) begin
               imu_beats_to_send.push_back(
                  imu_beat(KIND_SAMPLE, $urandom(), $urandom(), $urandom()));
            end else if (r < 85) begin
               // device near rest: gravity on one axis plus noise
               axis = $urandom_range(0, 2);
               g    = 4096 + int'($urandom_range(0, 3000)) - 1500;
               if ($urandom_range(0, 1) == 1) g = -g;
               x = int'($urandom_range(0, 2400)) - 1200;
               y = int'($urandom_range(0, 2400)) - 1200;
               z = int'($urandom_range(0, 2400)) - 1200;
               case (axis)
                  0: x = g;
                  1: y = g;
                  default: z = g;
               endcase
               imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE, x, y, z));
            end else begin
               // knocks and shakes, a few g per axis
               imu_beats_to_send.push_back(imu_beat(KIND_SAMPLE,
                  int'($urandom_range(0, 32000)) - 16000,
                  int'($urandom_range(0, 32000)) - 16000,
                  int'($urandom_range(0, 32000)) - 16000));
            end
         end
      end

      wait_idle();
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("imu_motion_orientation_classifier test passed");
      end else begin
         $display("imu_motion_orientation_classifier test failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/imoc_pkg.sv
rtl/imoc_calc.sv
rtl/imu_motion_orientation_classifier.sv
sim/tb_imu_motion_orientation_classifier.sv
